// ===== hdl/kknt_pkg.sv =====
// ----------------------------------------------------------------------------
// kknt_pkg
// Shared types and opcodes for the sparse KKT infinity-norm tracker.
// ----------------------------------------------------------------------------
package kknt_pkg;

    localparam int unsigned IDX_W = 10;
    localparam int unsigned MAG_W = 63;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_P     = 3'd1,
        OP_A     = 3'd2,
        OP_B     = 3'd3,
        OP_READ  = 3'd4
    } t_opcode;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [63:0]      value_bits;
        logic [IDX_W-1:0] entry_index;
    } t_in_item;

    typedef struct packed {
        logic [MAG_W-1:0] column_norm;
        logic [MAG_W-1:0] a_row_norm;
        logic [MAG_W-1:0] b_row_norm;
    } t_out_item;

    // One read-modify-write request for a max table.
    typedef struct packed {
        logic             rd;     // read only, report value
        logic             clr;    // write zero
        logic             upd;    // raise to mag
        logic [IDX_W-1:0] idx;
    } t_tbl_req;

endpackage

// ===== hdl/kknt_max_table.sv =====
// ----------------------------------------------------------------------------
// kknt_max_table
// One running-maximum table in a synchronous memory. A request is issued in
// one cycle; data comes back the next cycle and is written back there.
// After reset a clearing pass writes zero to every entry, one per cycle;
// o_busy stays high until it has finished.
// ----------------------------------------------------------------------------
module kknt_max_table #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kknt_pkg::t_tbl_req         i_req,
    input  logic [kknt_pkg::MAG_W-1:0] i_mag,
    output logic [kknt_pkg::MAG_W-1:0] o_rdata,
    output logic                       o_busy
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [kknt_pkg::MAG_W-1:0] r_mem [DEPTH];
    logic [kknt_pkg::MAG_W-1:0] r_q;
    kknt_pkg::t_tbl_req         r_req;
    logic [kknt_pkg::MAG_W-1:0] r_mag;
    logic                       r_fwd_v;
    logic [kknt_pkg::MAG_W-1:0] r_fwd;
    logic                       n_in_rng;
    logic                       r_in_rng;
    logic                       r_init;
    logic [AW-1:0]              r_init_idx;
    logic [AW-1:0]              w_a;
    logic [AW-1:0]              w_ra;
    logic [kknt_pkg::MAG_W-1:0] w_old;
    logic [kknt_pkg::MAG_W-1:0] w_new;
    logic                       w_we;

    assign n_in_rng = ({22'd0, i_req.idx} < 32'(DEPTH));
    assign w_a      = AW'(i_req.idx);
    assign w_ra     = AW'(r_req.idx);

    always_ff @(posedge i_clk) begin
        r_q   <= r_mem[w_a];
        r_mag <= i_mag;
        r_req <= i_req;
    end

    // sweep every entry to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b1;
            r_init_idx <= '0;
        end else if (r_init) begin
            r_init_idx <= r_init_idx + AW'(1);
            if (r_init_idx == AW'(DEPTH - 1)) r_init <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v  <= 1'b0;
            r_in_rng <= 1'b0;
        end else begin
            r_in_rng <= n_in_rng;
            // forward the write of this cycle if the next request hits it
            r_fwd_v  <= w_we && (i_req.idx == r_req.idx);
        end
        r_fwd <= w_new;
    end

    always_comb begin
        w_old = r_fwd_v ? r_fwd : r_q;
        if (!r_in_rng) w_old = '0;
        w_new = w_old;
        w_we  = 1'b0;
        if (r_in_rng && r_req.clr) begin
            w_new = '0;
            w_we  = 1'b1;
        end else if (r_in_rng && r_req.upd && (r_mag > w_old)) begin
            w_new = r_mag;
            w_we  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_init) begin
            r_mem[r_init_idx] <= '0;
        end else if (w_we) begin
            r_mem[w_ra] <= w_new;
        end
    end

    assign o_rdata = w_old;
    assign o_busy  = r_init;

`ifndef SYNTHESIS
    a_clr_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.clr && i_req.upd)) else $error("clear and update together");
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_v |-> $past(w_we)) else $error("forward without write");
    a_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !r_req.clr) |-> (w_new > w_old)) else $error("table lowered");
    a_init_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !(i_req.rd || i_req.clr || i_req.upd))
        else $error("request during clearing pass");
`endif
endmodule

// ===== hdl/kkt_sparse_inf_norm_tracker_top.sv =====
// ----------------------------------------------------------------------------
// kkt_sparse_inf_norm_tracker_top
// A read goes through the table memories (flag r_rd_s1) and its result is
// then registered in r_od, with o_valid (r_ov) rising as it is.
// Throughput: one item per cycle, while input is not stalled, for clears,
// unused opcodes, A, B and diagonal P entries; an off-diagonal P entry holds
// input for a second column update through the same port; a read holds input
// while its table read is in flight, then while its result waits.
// Reset: synchronous, active low; the tables are then swept to zero, input
// held off until every sweep has finished.
// ----------------------------------------------------------------------------
module kkt_sparse_inf_norm_tracker_top #(
    parameter int unsigned MAX_COLS = 1024,
    parameter int unsigned MAX_ROWS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  kknt_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output kknt_pkg::t_out_item o_data
);
    logic                       w_acc;
    logic                       r_p2;      // second half of an off-diagonal P
    logic [kknt_pkg::IDX_W-1:0] r_p2_idx;
    logic [kknt_pkg::MAG_W-1:0] r_p2_mag;
    logic                       r_rd_s1;
    logic                       r_ov;
    kknt_pkg::t_out_item        r_od;
    kknt_pkg::t_tbl_req         w_creq, w_areq, w_breq;
    logic [kknt_pkg::MAG_W-1:0] w_mag, w_cmag;
    logic [kknt_pkg::MAG_W-1:0] w_cq, w_aq, w_bq;
    logic                       w_cbusy, w_abusy, w_bbusy, w_busy;
    logic                       w_op_p, w_op_a, w_op_b, w_op_c, w_op_r;

    // stall while clearing, during a second P update, or while a read result is on its way or waiting
    assign w_busy  = w_cbusy || w_abusy || w_bbusy;
    assign o_ready = !w_busy && !r_p2 && !r_rd_s1 && !(r_ov && !i_ready);
    assign w_acc   = i_valid && o_ready;
    assign w_mag   = i_data.value_bits[kknt_pkg::MAG_W-1:0];

    assign w_op_c = w_acc && (i_data.opcode == kknt_pkg::OP_CLEAR);
    assign w_op_p = w_acc && (i_data.opcode == kknt_pkg::OP_P);
    assign w_op_a = w_acc && (i_data.opcode == kknt_pkg::OP_A);
    assign w_op_b = w_acc && (i_data.opcode == kknt_pkg::OP_B);
    assign w_op_r = w_acc && (i_data.opcode == kknt_pkg::OP_READ);

    always_comb begin
        w_creq = '0;
        w_areq = '0;
        w_breq = '0;
        w_cmag = w_mag;
        if (r_p2) begin
            w_creq.upd = 1'b1;
            w_creq.idx = r_p2_idx;
            w_cmag     = r_p2_mag;
        end else begin
            w_creq.idx = (w_op_c || w_op_r) ? i_data.entry_index : i_data.col;
            w_creq.clr = w_op_c;
            w_creq.upd = w_op_p || w_op_a || w_op_b;
            w_creq.rd  = w_op_r;
            w_areq.idx = (w_op_c || w_op_r) ? i_data.entry_index : i_data.row;
            w_areq.clr = w_op_c;
            w_areq.upd = w_op_a;
            w_areq.rd  = w_op_r;
            w_breq.idx = w_areq.idx;
            w_breq.clr = w_op_c;
            w_breq.upd = w_op_b;
            w_breq.rd  = w_op_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2    <= 1'b0;
            r_rd_s1 <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_p2    <= w_op_p && (i_data.row != i_data.col);
            r_rd_s1 <= w_op_r;
            if (r_rd_s1)      r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
        r_p2_idx <= i_data.row;
        r_p2_mag <= w_mag;
        if (r_rd_s1) r_od <= '{column_norm: w_cq, a_row_norm: w_aq, b_row_norm: w_bq};
    end

    kknt_max_table #(.DEPTH(MAX_COLS)) u_col (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_creq), .i_mag(w_cmag), .o_rdata(w_cq),
        .o_busy(w_cbusy));
    kknt_max_table #(.DEPTH(MAX_ROWS)) u_arow (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_areq), .i_mag(w_mag), .o_rdata(w_aq),
        .o_busy(w_abusy));
    kknt_max_table #(.DEPTH(MAX_ROWS)) u_brow (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_breq), .i_mag(w_mag), .o_rdata(w_bq),
        .o_busy(w_bbusy));

    assign o_valid = r_ov;
    assign o_data  = r_od;

`ifndef SYNTHESIS
    a_no_acc_p2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2 |-> !w_acc) else $error("transfer during second P update");
    a_rd_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_s1 |=> o_valid) else $error("read result lost");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data))) else $error("result dropped");
`endif
endmodule
